// ----- hdl/ssws_pkg.sv -----
// Shared types and constants for the seven-segment write sequencer.
// Depends on nothing; every other file of the block uses it.
package ssws_pkg;

	// Command codes as they arrive on the command channel
	localparam logic [2:0] CMD_HEX_DIGIT  = 3'd0;
	localparam logic [2:0] CMD_RAW_SEGS   = 3'd1;
	localparam logic [2:0] CMD_HEX16_LINE = 3'd2;
	localparam logic [2:0] CMD_DEC16_LINE = 3'd3;
	localparam logic [2:0] CMD_HEX8       = 3'd4;
	localparam logic [2:0] CMD_CLEAR_ALL  = 3'd5;
	localparam logic [2:0] CMD_CLEAR_LINE = 3'd6;

	// Control byte patterns; the low three bits carry the digit address
	localparam logic [7:0] CTRL_HEX   = 8'b0101_1000;
	localparam logic [7:0] CTRL_RAW   = 8'b0111_1000;
	// Data bit7 set keeps the decimal point dark
	localparam logic [7:0] DP_DARK    = 8'h80;
	localparam logic [7:0] BLANK_SEGS = 8'b1000_0000;
	localparam logic [15:0] DEC_LIMIT = 16'd9999;
	// floor(x * 6554 / 2^16) == floor(x / 10) for every x up to 9999
	localparam logic [12:0] DEC_RECIP = 13'd6554;

	// Classified operation carried from front to back
	typedef enum logic [2:0] {
		OP_HEX1,
		OP_RAW1,
		OP_HEX16,
		OP_DEC16,
		OP_HEX8,
		OP_CLR_ALL,
		OP_CLR_LINE
	} op_t;

	// One command as it arrives
	typedef struct packed {
		logic [2:0]  command;
		logic [2:0]  digit_addr;
		logic [15:0] value;
		logic        dp_on;
		logic        line_bottom;
	} cmd_t;

	// One digit write as it leaves
	typedef struct packed {
		logic [7:0] control_byte;
		logic [7:0] data_byte;
		logic       last;
	} wr_t;

	// Queue entry between front and back
	typedef struct packed {
		op_t         op;
		logic [2:0]  addr;
		logic [15:0] value;
		logic        dp_on;
		logic        line_bottom;
	} desc_t;

	// Queue handshake seen by the back part
	typedef struct packed {
		logic  valid;
		desc_t data;
	} q_head_t;

endpackage

// ----- hdl/ssws_front.sv -----
// Front part: accepts commands, classifies them and pushes descriptors.
// Depends on ssws_pkg.
module ssws_front (
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  ssws_pkg::cmd_t    cmd,
	input  logic              q_full,
	output logic              q_push,
	output ssws_pkg::desc_t   q_data
);

	logic          known;
	ssws_pkg::op_t op;

	// Map command code to operation; the unused code is accepted and dropped
	always_comb begin
		known = 1'b1;
		op    = ssws_pkg::OP_HEX1;
		case (cmd.command)
			ssws_pkg::CMD_HEX_DIGIT:  op = ssws_pkg::OP_HEX1;
			ssws_pkg::CMD_RAW_SEGS:   op = ssws_pkg::OP_RAW1;
			ssws_pkg::CMD_HEX16_LINE: op = ssws_pkg::OP_HEX16;
			ssws_pkg::CMD_DEC16_LINE: op = ssws_pkg::OP_DEC16;
			ssws_pkg::CMD_HEX8:       op = ssws_pkg::OP_HEX8;
			ssws_pkg::CMD_CLEAR_ALL:  op = ssws_pkg::OP_CLR_ALL;
			ssws_pkg::CMD_CLEAR_LINE: op = ssws_pkg::OP_CLR_LINE;
			default:                  known = 1'b0;
		endcase
	end

	// Build descriptor; a decimal value out of range shows as zero
	always_comb begin
		q_data.op          = op;
		q_data.addr        = cmd.digit_addr;
		q_data.dp_on       = cmd.dp_on;
		q_data.line_bottom = cmd.line_bottom;
		if (op == ssws_pkg::OP_DEC16 && cmd.value > ssws_pkg::DEC_LIMIT) begin
			q_data.value = '0;
		end else begin
			q_data.value = cmd.value;
		end
	end

	// Hold the sender while the queue is full
	assign cmd_stall = q_full;
	assign q_push    = cmd_valid && !q_full && known;

endmodule

// ----- hdl/ssws_queue.sv -----
// Short descriptor queue between front and back parts.
// Depends on ssws_pkg.
module ssws_queue #(
	parameter int DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ssws_pkg::desc_t   push_data,
	output logic              full,
	input  logic              pop,
	output ssws_pkg::q_head_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ssws_pkg::desc_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.data  = mem_q[rd_ptr_q];

	// Write entry at the tail
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/ssws_back.sv -----
// Back part: steps through one descriptor, one digit write per cycle while
// wr_stall is low, into a registered output. Depends on ssws_pkg.
module ssws_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ssws_pkg::q_head_t head,
	output logic              pop,
	output logic              wr_valid,
	input  logic              wr_stall,
	output ssws_pkg::wr_t     wr
);

	ssws_pkg::desc_t desc_q;
	logic [15:0]     work_q;
	logic [2:0]      step_q;
	logic            busy_q;
	logic            wr_valid_q;
	ssws_pkg::wr_t   wr_q;

	logic            out_free;
	logic            fire;
	logic            is_last;
	logic            load;
	logic            raw;
	logic [2:0]      addr;
	logic [7:0]      data;
	logic [15:0]     work_next;
	logic [26:0]     prod;
	logic [10:0]     quot;
	logic [13:0]     rem_wide;

	// Divide by ten through the reciprocal
	assign prod     = work_q[13:0] * ssws_pkg::DEC_RECIP;
	assign quot     = prod[26:16];
	assign rem_wide = work_q[13:0] - ({3'b000, quot} * 14'd10);

	// Select address, data, end of run and next work value per operation
	always_comb begin
		raw       = 1'b0;
		addr      = desc_q.addr;
		data      = ssws_pkg::DP_DARK | {1'b0, work_q[6:0]};
		is_last   = 1'b1;
		work_next = work_q;
		case (desc_q.op)
			ssws_pkg::OP_HEX1: begin
				data = desc_q.dp_on ? {1'b0, work_q[6:0]}
				                    : (ssws_pkg::DP_DARK | {1'b0, work_q[6:0]});
			end
			ssws_pkg::OP_RAW1: begin
				raw  = 1'b1;
				data = work_q[7:0];
			end
			ssws_pkg::OP_HEX16: begin
				addr      = {desc_q.line_bottom, ~step_q[1:0]};
				is_last   = (step_q == 3'd3);
				work_next = {4'b0000, work_q[15:4]};
			end
			ssws_pkg::OP_DEC16: begin
				addr      = {desc_q.line_bottom, ~step_q[1:0]};
				data      = ssws_pkg::DP_DARK | {4'b0000, rem_wide[3:0]};
				is_last   = (step_q == 3'd3);
				work_next = {5'b00000, quot};
			end
			ssws_pkg::OP_HEX8: begin
				is_last = (step_q == 3'd1);
				if (step_q[0]) begin
					addr = desc_q.addr + 3'd1;
					data = ssws_pkg::DP_DARK | {4'b0000, work_q[3:0]};
				end else begin
					data = ssws_pkg::DP_DARK | {4'b0000, work_q[7:4]};
				end
			end
			ssws_pkg::OP_CLR_ALL: begin
				raw     = 1'b1;
				addr    = step_q;
				data    = ssws_pkg::BLANK_SEGS;
				is_last = (step_q == 3'd7);
			end
			ssws_pkg::OP_CLR_LINE: begin
				raw     = 1'b1;
				addr    = {desc_q.line_bottom, step_q[1:0]};
				data    = ssws_pkg::BLANK_SEGS;
				is_last = (step_q == 3'd3);
			end
			default: begin
				is_last = 1'b1;
			end
		endcase
	end

	// Issue when the output register frees; take the next run without a gap
	assign out_free = !wr_valid_q || !wr_stall;
	assign fire     = busy_q && out_free;
	assign load     = head.valid && (!busy_q || (fire && is_last));
	assign pop      = load;

	// Hold descriptor and walk its steps
	always_ff @(posedge clk) begin
		if (load) begin
			desc_q <= head.data;
			work_q <= head.data.value;
		end else if (fire) begin
			work_q <= work_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (fire) begin
				if (is_last) begin
					busy_q <= 1'b0;
				end
				step_q <= step_q + 3'd1;
			end
		end
	end

	// Output register: hold while stalled, drop valid after a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_q <= 1'b0;
		end else if (fire) begin
			wr_valid_q <= 1'b1;
		end else if (!wr_stall) begin
			wr_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			wr_q.control_byte <= raw ? {ssws_pkg::CTRL_RAW[7:3], addr}
			                         : {ssws_pkg::CTRL_HEX[7:3], addr};
			wr_q.data_byte    <= data;
			wr_q.last         <= is_last;
		end
	end

	assign wr_valid = wr_valid_q;
	assign wr       = wr_q;

endmodule

// ----- hdl/seven_segment_write_sequencer.sv -----
// Seven-segment write sequencer: command channel in, digit-write channel out.
// Uses ssws_pkg, ssws_front, ssws_queue and ssws_back.
//
// Each accepted command on cmd (cmd_valid high, cmd_stall low) becomes a run
// of one to eight digit writes on wr, each a control byte and a data byte,
// with last set on the final write of the run. Command code 7 is taken and
// gives no writes.
// The front decodes a command in its accept cycle and pushes it into a
// QUEUE_DEPTH-entry queue; cmd_stall is high only while that queue is full.
// The back takes one queue entry at a time and, while wr_stall is low, issues
// one write per cycle: single-digit commands give one write, hex8 two, line
// commands four, clear-all eight. A new run starts in the cycle after the
// last write of the previous run, so writes leave back to back. A command
// reaches wr through the queue, then the descriptor and output registers.
// Decimal digits come from a divide-by-ten reciprocal multiply, one digit per
// cycle while unstalled. When wr_stall is high the registered write holds and
// the back pauses; the queue then fills and stalls the command side.
// Reset clears the queue, the sequencer and the output valid at once.
module seven_segment_write_sequencer #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  ssws_pkg::cmd_t  cmd,
	output logic            wr_valid,
	input  logic            wr_stall,
	output ssws_pkg::wr_t   wr
);

	logic              q_push;
	logic              q_full;
	logic              q_pop;
	ssws_pkg::desc_t   q_data;
	ssws_pkg::q_head_t q_head;

	ssws_front u_front (
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_data)
	);

	ssws_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head)
	);

	ssws_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.pop      (q_pop),
		.wr_valid (wr_valid),
		.wr_stall (wr_stall),
		.wr       (wr)
	);

endmodule
